// File: src/length_framed_packet_deframer_unit_macros.svh
`ifndef LENGTH_FRAMED_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_FRAMED_PACKET_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked on i_clk outside of reset.
`define LFPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside of reset.
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lfpd_pkg.sv
`default_nettype none

package lfpd_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_START_MARKER   = 2'd0;
    localparam logic [1:0] REG_TRAILER_FIRST  = 2'd1;
    localparam logic [1:0] REG_TRAILER_SECOND = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START_MARKER   = 8'd170;
    localparam logic [BYTE_W-1:0] RST_TRAILER_FIRST  = 8'd13;
    localparam logic [BYTE_W-1:0] RST_TRAILER_SECOND = 8'd10;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] trailer_first;
        logic [BYTE_W-1:0] trailer_second;
    } t_cfg;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_LENGTH  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_TRAIL1  = 5'b01000,
        PH_TRAIL2  = 5'b10000
    } t_phase;

endpackage

`default_nettype wire

// File: src/lfpd_if.sv
`default_nettype none

interface lfpd_rx_if;
    logic                        valid;
    logic                        ready;
    logic [lfpd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfpd_pl_if;
    logic                        valid;
    logic                        ready;
    logic [lfpd_pkg::BYTE_W-1:0] payload_byte;
    logic [lfpd_pkg::POS_W-1:0]  byte_position;
    logic [lfpd_pkg::LEN_W-1:0]  frame_length;
    logic                        last_of_frame;

    modport source (output valid, output payload_byte, output byte_position,
                    output frame_length, output last_of_frame, input ready);
    modport sink   (input valid, input payload_byte, input byte_position,
                    input frame_length, input last_of_frame, output ready);
endinterface

`default_nettype wire

// File: src/lfpd_cfg_regs.sv
`default_nettype none

module lfpd_cfg_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready,
    output lfpd_pkg::t_cfg      o_cfg
);

    lfpd_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker   <= lfpd_pkg::RST_START_MARKER;
            r_cfg.trailer_first  <= lfpd_pkg::RST_TRAILER_FIRST;
            r_cfg.trailer_second <= lfpd_pkg::RST_TRAILER_SECOND;
        end else if (wr_en) begin
            case (reg_idx)
                lfpd_pkg::REG_START_MARKER: begin
                    r_cfg.start_marker <= pwdata[7:0];
                end
                lfpd_pkg::REG_TRAILER_FIRST: begin
                    r_cfg.trailer_first <= pwdata[7:0];
                end
                lfpd_pkg::REG_TRAILER_SECOND: begin
                    r_cfg.trailer_second <= pwdata[7:0];
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lfpd_pkg::REG_START_MARKER:   prdata = {24'd0, r_cfg.start_marker};
            lfpd_pkg::REG_TRAILER_FIRST:  prdata = {24'd0, r_cfg.trailer_first};
            lfpd_pkg::REG_TRAILER_SECOND: prdata = {24'd0, r_cfg.trailer_second};
            default:                      prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/length_framed_packet_deframer_unit.sv
`default_nettype none

// Frame deframer: bytes arrive on i_rx as start marker, length, payload and two
// trailer bytes. While no frame is being read out, one byte is taken every
// cycle; payload bytes are written to a MAX_PAYLOAD x 8 store. After a matching
// second trailer byte the payload is read back from the store and sent on o_pl,
// each byte passing through a store read and then the output register; the
// input is held off until the store has been read out, and an empty frame
// sends a zero byte. Mismatching trailers or lengths above MAX_PAYLOAD drop the frame.
// Registers: start_marker at 0x0, trailer_first at 0x4, trailer_second at 0x8.

`include "length_framed_packet_deframer_unit_macros.svh"

module length_framed_packet_deframer_unit #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lfpd_rx_if.sink          i_rx,
    lfpd_pl_if.source        o_pl,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [lfpd_pkg::BYTE_W-1:0] MAX_LEN_B = lfpd_pkg::BYTE_W'(MAX_PAYLOAD);

    lfpd_pkg::t_cfg cfg;

    lfpd_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Parser state
    lfpd_pkg::t_phase                r_phase, n_phase;
    logic [lfpd_pkg::LEN_W-1:0]      r_exp_len, n_exp_len;
    logic [lfpd_pkg::LEN_W-1:0]      r_rcv_cnt, n_rcv_cnt;
    logic                            store_we;
    logic                            commit;

    // Payload store
    logic [lfpd_pkg::BYTE_W-1:0]     r_store [MAX_PAYLOAD];
    logic [lfpd_pkg::BYTE_W-1:0]     r_rd_data;

    // Readout sequencer
    logic                            r_rd_active;
    logic [lfpd_pkg::LEN_W-1:0]      r_rd_cnt;
    logic [lfpd_pkg::LEN_W-1:0]      r_rd_len;
    logic                            r_pend;
    logic [lfpd_pkg::POS_W-1:0]      r_pend_pos;
    logic                            r_pend_last;
    logic                            rd_issue;
    logic                            rd_last;
    logic [lfpd_pkg::LEN_W-1:0]      rd_cnt_inc;

    // Output register
    logic                            r_out_valid;
    logic [lfpd_pkg::BYTE_W-1:0]     r_out_byte;
    logic [lfpd_pkg::POS_W-1:0]      r_out_pos;
    logic [lfpd_pkg::LEN_W-1:0]      r_out_len;
    logic                            r_out_last;

    logic                            busy;
    logic                            rx_xfer;
    logic [lfpd_pkg::BYTE_W-1:0]     rx_b;

    // Hold off input until the store has been read out
    assign busy       = r_rd_active || r_pend;
    assign i_rx.ready = !busy;
    assign rx_xfer    = i_rx.valid && !busy;
    assign rx_b       = i_rx.rx_byte;

    always_comb begin
        n_phase   = r_phase;
        n_exp_len = r_exp_len;
        n_rcv_cnt = r_rcv_cnt;
        store_we  = 1'b0;
        commit    = 1'b0;
        if (rx_xfer) begin
            case (r_phase)
                lfpd_pkg::PH_LENGTH: begin
                    n_rcv_cnt = '0;
                    if (rx_b > MAX_LEN_B) begin
                        n_exp_len = '0;
                        n_phase   = lfpd_pkg::PH_IDLE;
                    end else begin
                        n_exp_len = rx_b[lfpd_pkg::LEN_W-1:0];
                        n_phase   = (rx_b == 8'd0) ? lfpd_pkg::PH_TRAIL1
                                                   : lfpd_pkg::PH_PAYLOAD;
                    end
                end
                lfpd_pkg::PH_PAYLOAD: begin
                    store_we  = 1'b1;
                    n_rcv_cnt = r_rcv_cnt + 7'd1;
                    if (n_rcv_cnt >= r_exp_len) begin
                        n_phase = lfpd_pkg::PH_TRAIL1;
                    end
                end
                lfpd_pkg::PH_TRAIL1: begin
                    n_phase = (rx_b == cfg.trailer_first) ? lfpd_pkg::PH_TRAIL2
                                                          : lfpd_pkg::PH_IDLE;
                end
                lfpd_pkg::PH_TRAIL2: begin
                    n_phase = lfpd_pkg::PH_IDLE;
                    commit  = (rx_b == cfg.trailer_second);
                end
                default: begin
                    n_phase = (rx_b == cfg.start_marker) ? lfpd_pkg::PH_LENGTH
                                                         : lfpd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lfpd_pkg::PH_IDLE;
            r_exp_len <= '0;
            r_rcv_cnt <= '0;
        end else begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_rcv_cnt <= n_rcv_cnt;
        end
    end

    // Issue a read only when the output register is free by the time data returns
    assign rd_issue   = r_rd_active && !r_pend && (!r_out_valid || o_pl.ready);
    assign rd_cnt_inc = r_rd_cnt + 7'd1;
    assign rd_last    = (rd_cnt_inc >= r_rd_len);

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_rcv_cnt[AW-1:0]] <= rx_b;
        end
        if (rd_issue) begin
            r_rd_data <= r_store[r_rd_cnt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_active <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (commit) begin
                r_rd_active <= 1'b1;
            end else if (rd_issue && rd_last) begin
                r_rd_active <= 1'b0;
            end
            r_pend <= rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_rd_cnt <= '0;
            r_rd_len <= r_exp_len;
        end else if (rd_issue) begin
            r_rd_cnt <= rd_cnt_inc;
        end
        if (rd_issue) begin
            r_pend_pos  <= r_rd_cnt[lfpd_pkg::POS_W-1:0];
            r_pend_last <= rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= 1'b1;
        end else if (o_pl.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            // an empty frame carries a zero byte, not store contents
            r_out_byte <= (r_rd_len == 7'd0) ? 8'd0 : r_rd_data;
            r_out_pos  <= r_pend_pos;
            r_out_len  <= r_rd_len;
            r_out_last <= r_pend_last;
        end
    end

    assign o_pl.valid         = r_out_valid;
    assign o_pl.payload_byte  = r_out_byte;
    assign o_pl.byte_position = r_out_pos;
    assign o_pl.frame_length  = r_out_len;
    assign o_pl.last_of_frame = r_out_last;

    `LFPD_ASSERT_NOW(a_pend_slot_free, r_pend, (!r_out_valid || o_pl.ready), "output overrun")
    `LFPD_ASSERT_NOW(a_no_write_in_readout, store_we, (!r_rd_active && !r_pend), "store hazard")
    `LFPD_ASSERT_NOW(a_last_pos, (r_out_valid && r_out_last), ((r_out_len == 7'd0 && r_out_pos == 6'd0) || ({1'b0, r_out_pos} + 7'd1 == r_out_len)), "bad last")
    `LFPD_ASSERT_NEXT(a_commit_starts, commit, (r_rd_active && r_rd_cnt == 7'd0), "no readout")

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;

    localparam int STORE_DEPTH = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef logic [lfpd_pkg::BYTE_W-1:0] t_byte;
    typedef logic [lfpd_pkg::LEN_W-1:0]  t_len;

    typedef struct packed {
        logic [lfpd_pkg::BYTE_W-1:0] payload_byte;
        logic [lfpd_pkg::POS_W-1:0]  byte_position;
        logic [lfpd_pkg::LEN_W-1:0]  frame_length;
        logic                        last_of_frame;
    } t_pl_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lfpd_rx_if rx_if();
    lfpd_pl_if pl_if();

    length_framed_packet_deframer_unit #(
        .MAX_PAYLOAD(STORE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if.sink),
        .o_pl    (pl_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the deframer state
    lfpd_pkg::t_cfg              marker_cfg;
    lfpd_pkg::t_phase            parse_ph;
    logic [lfpd_pkg::LEN_W-1:0]  want_len;
    logic [lfpd_pkg::LEN_W-1:0]  got_cnt;
    logic [lfpd_pkg::BYTE_W-1:0] frame_store [STORE_DEPTH];
    t_pl_item                    pending_pl [$];

    int fail_cnt;
    int cycle_cnt;
    int bytes_sent;
    int frame_bytes;
    int frames_committed;
    int frames_dropped;
    int transfers_checked;
    int src_idle_pct;
    int snk_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void predict_rx(input logic [lfpd_pkg::BYTE_W-1:0] b);
        t_pl_item item;
        int k;
        case (parse_ph)
            lfpd_pkg::PH_LENGTH: begin
                got_cnt = '0;
                if (b > STORE_DEPTH) begin
                    want_len = '0;
                    parse_ph = lfpd_pkg::PH_IDLE;
                    frames_dropped++;
                end else begin
                    want_len = b[lfpd_pkg::LEN_W-1:0];
                    parse_ph = (want_len == 0) ? lfpd_pkg::PH_TRAIL1 : lfpd_pkg::PH_PAYLOAD;
                end
            end
            lfpd_pkg::PH_PAYLOAD: begin
                if (got_cnt < STORE_DEPTH) begin
                    frame_store[got_cnt[lfpd_pkg::POS_W-1:0]] = b;
                    got_cnt++;
                end
                if (got_cnt >= want_len || got_cnt >= STORE_DEPTH)
                    parse_ph = lfpd_pkg::PH_TRAIL1;
            end
            lfpd_pkg::PH_TRAIL1: begin
                if (b == marker_cfg.trailer_first) begin
                    parse_ph = lfpd_pkg::PH_TRAIL2;
                end else begin
                    parse_ph = lfpd_pkg::PH_IDLE;
                    frames_dropped++;
                end
            end
            lfpd_pkg::PH_TRAIL2: begin
                parse_ph = lfpd_pkg::PH_IDLE;
                if (b == marker_cfg.trailer_second) begin
                    frames_committed++;
                    if (want_len == 0) begin
                        item = '{payload_byte: '0, byte_position: '0,
                                 frame_length: '0, last_of_frame: 1'b1};
                        pending_pl.push_back(item);
                    end else begin
                        for (k = 0; k < want_len; k++) begin
                            item.payload_byte  = frame_store[k[lfpd_pkg::POS_W-1:0]];
                            item.byte_position = k[lfpd_pkg::POS_W-1:0];
                            item.frame_length  = want_len;
                            item.last_of_frame = (k == want_len - 1);
                            pending_pl.push_back(item);
                        end
                    end
                end else begin
                    frames_dropped++;
                end
            end
            default: parse_ph = (b == marker_cfg.start_marker) ? lfpd_pkg::PH_LENGTH
                                                               : lfpd_pkg::PH_IDLE;
        endcase
    endfunction

    // Payload receiver: random backpressure
    initial begin
        pl_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            pl_if.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    t_pl_item want_item;

    always @(posedge i_clk) begin
        if (i_rst_n && pl_if.valid && pl_if.ready) begin
            if (pending_pl.size() == 0) begin
                $error("unexpected payload transfer: byte %0d pos %0d len %0d last %0d",
                       pl_if.payload_byte, pl_if.byte_position, pl_if.frame_length,
                       pl_if.last_of_frame);
                fail_cnt++;
            end else begin
                want_item = pending_pl.pop_front();
                transfers_checked++;
                if (pl_if.payload_byte !== want_item.payload_byte) begin
                    $error("payload_byte: expected %0d, got %0d",
                           want_item.payload_byte, pl_if.payload_byte);
                    fail_cnt++;
                end
                if (pl_if.byte_position !== want_item.byte_position) begin
                    $error("byte_position: expected %0d, got %0d",
                           want_item.byte_position, pl_if.byte_position);
                    fail_cnt++;
                end
                if (pl_if.frame_length !== want_item.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want_item.frame_length, pl_if.frame_length);
                    fail_cnt++;
                end
                if (pl_if.last_of_frame !== want_item.last_of_frame) begin
                    $error("last_of_frame: expected %0d, got %0d",
                           want_item.last_of_frame, pl_if.last_of_frame);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic send_byte(input logic [lfpd_pkg::BYTE_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            rx_if.valid = 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do @(posedge i_clk); while (!rx_if.ready);
        predict_rx(b);
        bytes_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        rx_if.valid = 1'b0;
    endtask

    // Drop valid first so the last byte is not transferred twice
    task automatic wait_drained();
        stop_sending();
        while (pending_pl.size() != 0) @(posedge i_clk);
    endtask

    // Hold until the deframer has nothing left to emit or chew on
    task automatic wait_idle();
        stop_sending();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [lfpd_pkg::BYTE_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {24'($urandom_range(0, 32'hFFFFFF)), val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            lfpd_pkg::REG_START_MARKER:   marker_cfg.start_marker   = val;
            lfpd_pkg::REG_TRAILER_FIRST:  marker_cfg.trailer_first  = val;
            lfpd_pkg::REG_TRAILER_SECOND: marker_cfg.trailer_second = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [lfpd_pkg::BYTE_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {24'd0, val}) begin
            $error("register %0d: expected %0d, got %0d", idx, val, prdata);
            fail_cnt++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_markers();
        apb_check(lfpd_pkg::REG_START_MARKER, marker_cfg.start_marker);
        apb_check(lfpd_pkg::REG_TRAILER_FIRST, marker_cfg.trailer_first);
        apb_check(lfpd_pkg::REG_TRAILER_SECOND, marker_cfg.trailer_second);
    endtask

    task automatic set_markers(input logic [lfpd_pkg::BYTE_W-1:0] s,
                               input logic [lfpd_pkg::BYTE_W-1:0] t1,
                               input logic [lfpd_pkg::BYTE_W-1:0] t2);
        wait_idle();
        apb_write(lfpd_pkg::REG_START_MARKER, s);
        apb_write(lfpd_pkg::REG_TRAILER_FIRST, t1);
        apb_write(lfpd_pkg::REG_TRAILER_SECOND, t2);
        check_markers();
    endtask

    task automatic send_frame(input logic [lfpd_pkg::LEN_W-1:0] len, input bit pattern_fill);
        int k;
        send_byte(marker_cfg.start_marker);
        send_byte({1'b0, len});
        for (k = 0; k < len; k++)
            send_byte(pattern_fill ? ((k % 2) ? 8'hFF : 8'h00)
                                   : t_byte'($urandom_range(0, 255)));
        send_byte(marker_cfg.trailer_first);
        send_byte(marker_cfg.trailer_second);
        frame_bytes += len + 4;
    endtask

    task automatic test_register_access();
        check_markers();
        set_markers(8'h00, 8'h00, 8'h00);
        set_markers(8'hFF, 8'hFF, 8'hFF);
        // Unmapped index must leave all markers alone
        apb_write(REG_UNUSED, 8'h5A);
        check_markers();
        set_markers(lfpd_pkg::RST_START_MARKER, lfpd_pkg::RST_TRAILER_FIRST,
                    lfpd_pkg::RST_TRAILER_SECOND);
    endtask

    task automatic test_directed_frames();
        // empty frame
        send_frame(7'd0, 1'b0);
        // one byte at the top of the range, then both extremes
        send_byte(marker_cfg.start_marker);
        send_byte(8'd1);
        send_byte(8'hFF);
        send_byte(marker_cfg.trailer_first);
        send_byte(marker_cfg.trailer_second);
        send_frame(7'd2, 1'b1);
        // oversize lengths drop the frame
        send_byte(marker_cfg.start_marker);
        send_byte(8'd65);
        send_byte(marker_cfg.start_marker);
        send_byte(8'hFF);
        // wrong first trailer byte
        send_byte(marker_cfg.start_marker);
        send_byte(8'd0);
        send_byte(~marker_cfg.trailer_first);
        // wrong second trailer byte
        send_byte(marker_cfg.start_marker);
        send_byte(8'd0);
        send_byte(marker_cfg.trailer_first);
        send_byte(~marker_cfg.trailer_second);
        frame_bytes = 0;
    endtask

    task automatic send_random_frame(input bit force_long);
        int kind;
        int k;
        logic [lfpd_pkg::LEN_W-1:0] len;
        kind = $urandom_range(99);
        if (force_long)
            len = t_len'(STORE_DEPTH);
        else if ($urandom_range(19) == 0)
            len = t_len'($urandom_range(33, STORE_DEPTH));
        else
            len = t_len'($urandom_range(0, 12));
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(t_byte'($urandom_range(0, 255)));
        end
        if (force_long) kind = 99;
        send_byte(marker_cfg.start_marker);
        frame_bytes++;
        if (kind < 5) begin
            send_byte(t_byte'($urandom_range(STORE_DEPTH + 1, 255)));
            frame_bytes++;
            return;
        end
        send_byte({1'b0, len});
        for (k = 0; k < len; k++)
            send_byte(t_byte'($urandom_range(0, 255)));
        frame_bytes += len + 1;
        if (kind < 11) begin
            send_byte(marker_cfg.trailer_first ^ t_byte'($urandom_range(1, 255)));
            frame_bytes++;
            return;
        end
        send_byte(marker_cfg.trailer_first);
        if (kind < 17)
            send_byte(marker_cfg.trailer_second ^ t_byte'($urandom_range(1, 255)));
        else
            send_byte(marker_cfg.trailer_second);
        frame_bytes += 2;
    endtask

    task automatic test_random_frames(input int src_pct, input int snk_pct, input int n_bytes,
                                      input bit long_first);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        frame_bytes  = 0;
        if (long_first) begin
            send_random_frame(1'b1);
            // let the whole run drain before the next frame
            wait_drained();
        end
        while (frame_bytes < n_bytes) begin
            send_random_frame(1'b0);
            if ($urandom_range(11) == 0) wait_drained();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        fail_cnt          = 0;
        cycle_cnt         = 0;
        bytes_sent        = 0;
        frame_bytes       = 0;
        frames_committed  = 0;
        frames_dropped    = 0;
        transfers_checked = 0;
        src_idle_pct      = 0;
        snk_idle_pct      = 0;
        marker_cfg = '{start_marker: lfpd_pkg::RST_START_MARKER,
                       trailer_first: lfpd_pkg::RST_TRAILER_FIRST,
                       trailer_second: lfpd_pkg::RST_TRAILER_SECOND};
        parse_ph = lfpd_pkg::PH_IDLE;
        want_len = '0;
        got_cnt  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_access();
        src_idle_pct = 26;
        snk_idle_pct = 68;
        test_directed_frames();
        set_markers(8'h00, 8'hFF, 8'h00);
        test_random_frames(26, 68, 135, 1'b1);
        set_markers(t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                    t_byte'($urandom_range(0, 255)));
        test_random_frames(68, 26, 135, 1'b0);
        set_markers(8'hFF, 8'h00, 8'hFF);
        test_random_frames(0, 0, 135, 1'b1);

        stop_sending();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes: %0d frames committed, %0d dropped", bytes_sent,
                 frames_committed, frames_dropped);
        $display("checked %0d payload transfers under four marker settings", transfers_checked);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
